[design/ttb_pkg.sv]
// ----------------------------------------------------------------------------
// ttb_pkg: shared constants of the triangle tangent unit
// Default widths, the arithmetic constants of the normalizer and the
// configuration register map.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int CoordWidthDef  = 32;
  localparam int OutFracBitsDef = 14;

  // Width of one multiplier digit in the product sequencer.
  localparam int ChunkW = 16;
  // The normalizer brings the largest magnitude into [2^(NormBits-1), 2^NormBits).
  localparam int NormBits = 30;
  // Number of signed differences carried by one triangle job.
  localparam int JobFields = 10;

  // Configuration port.
  localparam int   CfgAddrW         = 3;
  localparam logic RegComputeEnable = 1'b0;

endpackage

[design/ttb_front.sv]
// ----------------------------------------------------------------------------
// ttb_front: vertex intake
// Holds the first two vertices of a triangle and forms the edge and texture
// deltas when the third arrives.
// ----------------------------------------------------------------------------
module ttb_front #(
  parameter int COORD_WIDTH = ttb_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_WIDTH-1:0]        pos_x_i,
  input  logic [COORD_WIDTH-1:0]        pos_y_i,
  input  logic [COORD_WIDTH-1:0]        pos_z_i,
  input  logic [COORD_WIDTH-1:0]        tex_u_i,
  input  logic [COORD_WIDTH-1:0]        tex_v_i,
  input  logic                          enable_i,
  input  logic                          job_full_i,
  output logic                          job_push_o,
  output logic [ttb_pkg::JobFields*(COORD_WIDTH+1)-1:0] job_o
);

  localparam logic [1:0] PH_V0 = 2'd0;
  localparam logic [1:0] PH_V1 = 2'd1;
  localparam logic [1:0] PH_V2 = 2'd2;

  logic [1:0]             phase_q;
  logic [COORD_WIDTH-1:0] p0_q [3];
  logic [COORD_WIDTH-1:0] p1_q [3];
  logic [COORD_WIDTH-1:0] t0_q [2];
  logic [COORD_WIDTH-1:0] t1_q [2];
  logic                   third;
  logic                   accept;

  function automatic logic [COORD_WIDTH:0] sdiff(input logic [COORD_WIDTH-1:0] a,
                                                 input logic [COORD_WIDTH-1:0] b);
    sdiff = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  assign third      = (phase_q == PH_V2);
  assign in_ready_o = !third || !enable_i || !job_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign job_push_o = in_valid_i && third && enable_i && !job_full_i;

  assign job_o = {sdiff(p1_q[0], p0_q[0]), sdiff(p1_q[1], p0_q[1]), sdiff(p1_q[2], p0_q[2]),
                  sdiff(pos_x_i, p0_q[0]), sdiff(pos_y_i, p0_q[1]), sdiff(pos_z_i, p0_q[2]),
                  sdiff(t1_q[0], t0_q[0]), sdiff(t1_q[1], t0_q[1]),
                  sdiff(tex_u_i, t0_q[0]), sdiff(tex_v_i, t0_q[1])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_V0;
    end else if (accept) begin
      case (phase_q)
        PH_V1:   phase_q <= PH_V2;
        PH_V2:   phase_q <= PH_V0;
        default: phase_q <= PH_V1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_V1) begin
      p1_q[0] <= pos_x_i;
      p1_q[1] <= pos_y_i;
      p1_q[2] <= pos_z_i;
      t1_q[0] <= tex_u_i;
      t1_q[1] <= tex_v_i;
    end else if (accept && !third) begin
      p0_q[0] <= pos_x_i;
      p0_q[1] <= pos_y_i;
      p0_q[2] <= pos_z_i;
      t0_q[0] <= tex_u_i;
      t0_q[1] <= tex_v_i;
    end
  end

endmodule

[design/ttb_fifo.sv]
// ----------------------------------------------------------------------------
// ttb_fifo: two-entry job queue
// Decouples vertex intake from the tangent sequencer.
// ----------------------------------------------------------------------------
module ttb_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q;
  logic         rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

[design/ttb_back.sv]
// ----------------------------------------------------------------------------
// ttb_back: tangent sequencer
// Forms the determinant and both cross combinations with one digit-serial
// multiplier, then normalizes each vector with a shifter, a square root and a
// divider, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ttb_back #(
  parameter int COORD_WIDTH   = ttb_pkg::CoordWidthDef,
  parameter int OUT_FRAC_BITS = ttb_pkg::OutFracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_empty_i,
  output logic                         job_pop_o,
  input  logic [ttb_pkg::JobFields*(COORD_WIDTH+1)-1:0] job_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [OUT_FRAC_BITS+1:0]     tangent_x_o,
  output logic [OUT_FRAC_BITS+1:0]     tangent_y_o,
  output logic [OUT_FRAC_BITS+1:0]     tangent_z_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_x_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_y_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_z_o,
  output logic                         degenerate_o
);

  localparam int D   = COORD_WIDTH + 1;
  localparam int PW  = 2 * D;
  localparam int CH  = ttb_pkg::ChunkW;
  localparam int NCH = (D + CH - 1) / CH;
  localparam int BPW = NCH * CH;
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int NB  = ttb_pkg::NormBits;
  localparam int SQW = 2 * NB + 2;
  localparam int RW  = NB + 1;
  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int QB  = OW;
  localparam int DW  = NB + OUT_FRAC_BITS + 1;
  localparam int RMW = RW + 1;
  localparam int QCW = $clog2(QB + 1);
  localparam int NF  = ttb_pkg::JobFields;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_FIX   = 4'd3;
  localparam logic [3:0] S_MAX   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIVLD = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]    state_q, state_d;

  // job operands
  logic [D-1:0]  e1_q [3];
  logic [D-1:0]  e2_q [3];
  logic [D-1:0]  du1_q, dv1_q, du2_q, dv2_q;

  // product sequencer
  logic [KW-1:0] k_q;
  logic          t_q;
  logic [2:0]    r_q;
  logic          last_step;
  logic [1:0]    comp;
  logic [D-1:0]  e1s, e2s, op_a, op_b, mag_a, mag_b;
  logic [BPW-1:0] mag_b_pad;
  logic [CH-1:0] chunk;
  logic [D+CH-1:0] pp_d, pp_q;
  logic [KW-1:0] pp_k_q;
  logic [2:0]    pp_r_q;
  logic          pp_neg_q, pp_vld_q;
  logic [PW-1:0] add_term;
  logic [PW-1:0] res_q [7];

  // normalizer
  logic          vec_q;
  logic          degen_q;
  logic [PW-1:0] vr [3];
  logic [PW-1:0] m_q [3];
  logic          sgn_q [3];
  logic [PW-1:0] big_q, big01;
  logic          det_zero, det_neg;
  logic [1:0]    i_q;
  logic [NB-1:0] cur_c;
  logic [2*NB-1:0] sq_q;
  logic [SQW-1:0] sum_q, rs_q, root_q, bit_q, sq_trial;
  logic [RW-1:0] len_q;
  logic [DW-1:0] dvd;
  logic [RMW-1:0] rem_q, div_trial;
  logic [QB-1:0] dvq_q, quo_q, q_final;
  logic [QCW-1:0] qc_q;
  logic          div_ge;
  logic [OW-1:0] q_signed;
  logic [OW-1:0] rt_q [3];
  logic [OW-1:0] rb_q [3];
  logic          out_valid_q;

  assign job_pop_o = (state_q == S_IDLE) && !job_empty_i;
  assign last_step = (k_q == KW'(NCH - 1)) && t_q && (r_q == 3'd6);

  // Operand selection: det = du1*dv2 - du2*dv1, tangent = dv2*e1 - dv1*e2,
  // bitangent = du1*e2 - du2*e1.
  always_comb begin
    case (r_q)
      3'd1, 3'd4: comp = 2'd0;
      3'd2, 3'd5: comp = 2'd1;
      default:    comp = 2'd2;
    endcase
    e1s = e1_q[comp];
    e2s = e2_q[comp];
    case (r_q)
      3'd0: begin
        op_a = t_q ? du2_q : du1_q;
        op_b = t_q ? dv1_q : dv2_q;
      end
      3'd1, 3'd2, 3'd3: begin
        op_a = t_q ? dv1_q : dv2_q;
        op_b = t_q ? e2s : e1s;
      end
      default: begin
        op_a = t_q ? du2_q : du1_q;
        op_b = t_q ? e1s : e2s;
      end
    endcase
  end

  assign mag_a     = op_a[D-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b     = op_b[D-1] ? (~op_b + 1'b1) : op_b;
  assign mag_b_pad = BPW'(mag_b);
  assign chunk     = mag_b_pad[k_q*CH +: CH];
  assign pp_d      = (D+CH)'(mag_a) * (D+CH)'(chunk);
  assign add_term  = PW'(pp_q) << (pp_k_q * CH);

  assign det_neg  = res_q[0][PW-1];
  assign det_zero = (res_q[0] == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vr[i] = vec_q ? res_q[4+i] : res_q[1+i];
    end
    big01 = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  end

  assign cur_c    = m_q[i_q][NB-1:0];
  assign sq_trial = root_q + bit_q;
  assign dvd      = (DW'(cur_c) << OUT_FRAC_BITS) + DW'(len_q >> 1);
  assign div_trial = {rem_q[RMW-2:0], dvq_q[QB-1]};
  assign div_ge   = (div_trial >= RMW'(len_q));
  assign q_final  = {quo_q[QB-2:0], div_ge};
  assign q_signed = sgn_q[i_q] ? (~q_final + 1'b1) : q_final;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (!job_empty_i) state_d = S_MUL;
      S_MUL:   if (last_step) state_d = S_DRAIN;
      S_DRAIN: state_d = S_FIX;
      S_FIX:   state_d = det_zero ? S_OUT : S_MAX;
      S_MAX:   state_d = S_NORM;
      S_NORM: begin
        if (big_q == '0) begin
          state_d = S_OUT;
        end else if (big_q[PW-1:NB] == '0 && big_q[NB-1]) begin
          state_d = S_SQ;
        end
      end
      S_SQ:    if (i_q == 2'd3) state_d = S_SQRT;
      S_SQRT:  if (bit_q == '0) state_d = S_DIVLD;
      S_DIVLD: state_d = S_DIV;
      S_DIV: begin
        if (qc_q == QCW'(QB - 1)) begin
          if (i_q != 2'd2) begin
            state_d = S_DIVLD;
          end else begin
            state_d = vec_q ? S_OUT : S_FIX;
          end
        end
      end
      S_OUT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      t_q         <= 1'b0;
      r_q         <= 3'd0;
      i_q         <= 2'd0;
      qc_q        <= '0;
      vec_q       <= 1'b0;
      degen_q     <= 1'b0;
      pp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pp_vld_q <= (state_q == S_MUL);
      case (state_q)
        S_IDLE: begin
          k_q     <= '0;
          t_q     <= 1'b0;
          r_q     <= 3'd0;
          vec_q   <= 1'b0;
          degen_q <= 1'b0;
        end
        S_MUL: begin
          if (k_q == KW'(NCH - 1)) begin
            k_q <= '0;
            t_q <= !t_q;
            if (t_q) begin
              r_q <= r_q + 3'd1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_FIX: begin
          i_q <= 2'd0;
          if (det_zero) begin
            degen_q <= 1'b1;
          end
        end
        S_NORM: begin
          if (big_q == '0) begin
            degen_q <= 1'b1;
          end
        end
        S_SQ: begin
          i_q <= (i_q == 2'd3) ? 2'd0 : i_q + 2'd1;
        end
        S_DIVLD: begin
          qc_q <= '0;
        end
        S_DIV: begin
          qc_q <= qc_q + 1'b1;
          if (qc_q == QCW'(QB - 1)) begin
            if (i_q != 2'd2) begin
              i_q <= i_q + 2'd1;
            end else begin
              vec_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    pp_k_q   <= k_q;
    pp_r_q   <= r_q;
    pp_neg_q <= op_a[D-1] ^ op_b[D-1] ^ t_q;

    if (job_pop_o) begin
      for (int f = 0; f < 3; f++) begin
        e1_q[f] <= job_i[(NF-1-f)*D +: D];
        e2_q[f] <= job_i[(NF-4-f)*D +: D];
      end
      du1_q <= job_i[3*D +: D];
      dv1_q <= job_i[2*D +: D];
      du2_q <= job_i[D +: D];
      dv2_q <= job_i[0 +: D];
    end

    for (int e = 0; e < 7; e++) begin
      if (job_pop_o) begin
        res_q[e] <= '0;
      end else if (pp_vld_q && pp_r_q == 3'(e)) begin
        res_q[e] <= pp_neg_q ? res_q[e] - add_term : res_q[e] + add_term;
      end
    end

    case (state_q)
      S_FIX: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= vr[i][PW-1] ? (~vr[i] + 1'b1) : vr[i];
          sgn_q[i] <= vr[i][PW-1] ^ det_neg;
        end
      end
      S_MAX: begin
        big_q <= (big01 > m_q[2]) ? big01 : m_q[2];
      end
      S_NORM: begin
        if (big_q[PW-1:NB] != '0) begin
          big_q <= big_q >> 1;
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= m_q[i] >> 1;
          end
        end else if (!big_q[NB-1]) begin
          big_q <= big_q << 1;
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      S_SQ: begin
        sq_q  <= (2*NB)'(cur_c) * (2*NB)'(cur_c);
        sum_q <= (i_q == 2'd0) ? '0 : sum_q + SQW'(sq_q);
        if (i_q == 2'd3) begin
          rs_q   <= sum_q + SQW'(sq_q);
          root_q <= '0;
          bit_q  <= SQW'(1) << (SQW - 2);
        end
      end
      S_SQRT: begin
        if (bit_q == '0) begin
          len_q <= root_q[RW-1:0];
        end else begin
          if (rs_q >= sq_trial) begin
            rs_q   <= rs_q - sq_trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_DIVLD: begin
        rem_q <= RMW'(dvd >> QB);
        dvq_q <= dvd[QB-1:0];
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_trial - RMW'(len_q) : div_trial;
        dvq_q <= dvq_q << 1;
        quo_q <= q_final;
        if (qc_q == QCW'(QB - 1)) begin
          for (int i = 0; i < 3; i++) begin
            if (i_q == 2'(i)) begin
              if (vec_q) begin
                rb_q[i] <= q_signed;
              end else begin
                rt_q[i] <= q_signed;
              end
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          tangent_x_o   <= degen_q ? '0 : rt_q[0];
          tangent_y_o   <= degen_q ? '0 : rt_q[1];
          tangent_z_o   <= degen_q ? '0 : rt_q[2];
          bitangent_x_o <= degen_q ? '0 : rb_q[0];
          bitangent_y_o <= degen_q ? '0 : rb_q[1];
          bitangent_z_o <= degen_q ? '0 : rb_q[2];
          degenerate_o  <= degen_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/triangle_tangent_bitangent_top.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_top: per-triangle unit tangent and bitangent
// Takes vertices three to a triangle and returns one normalized tangent and
// bitangent pair in signed Q1.OUT_FRAC_BITS for each triangle taken while compute_enable is set.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  -------   -----------------------------   ---------------------------------
//  vertex    in_valid_i / in_ready_o         pos_x/y/z_i, tex_u/v_i (Q16.16)
//  result    out_valid_o / out_ready_i       tangent_*_o, bitangent_*_o,
//                                            degenerate_o
//  config    psel/penable/pwrite, pready     paddr, pwdata, prdata
//
// The first two vertices of a triangle are always accepted. The third is
// accepted unless compute_enable is set and both entries of the job queue are full.
// Each triangle then occupies the sequencer for the products on the one shared
// multiplier and, per vector, for sign fixing and shifting, the squares, the
// square-root steps and the divider steps.
// Reset clears the vertex phase, the queue and the sequencer and sets
// compute_enable. A stalled result holds in the output register; the sequencer
// waits for it while the intake keeps filling the queue.
//
// Register map: compute_enable at byte address 0 (bit 0). When it is clear,
// vertices are still counted so triangle alignment is kept, but the third
// vertex of a triangle raises no request towards the sequencer.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_top #(
  parameter int COORD_WIDTH   = ttb_pkg::CoordWidthDef,
  parameter int OUT_FRAC_BITS = ttb_pkg::OutFracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [COORD_WIDTH-1:0]       pos_x_i,
  input  logic [COORD_WIDTH-1:0]       pos_y_i,
  input  logic [COORD_WIDTH-1:0]       pos_z_i,
  input  logic [COORD_WIDTH-1:0]       tex_u_i,
  input  logic [COORD_WIDTH-1:0]       tex_v_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [OUT_FRAC_BITS+1:0]     tangent_x_o,
  output logic [OUT_FRAC_BITS+1:0]     tangent_y_o,
  output logic [OUT_FRAC_BITS+1:0]     tangent_z_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_x_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_y_o,
  output logic [OUT_FRAC_BITS+1:0]     bitangent_z_o,
  output logic                         degenerate_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttb_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int JW = ttb_pkg::JobFields * (COORD_WIDTH + 1);

  logic          enable_q;
  logic          cfg_wr;
  logic          job_push, job_pop, job_full, job_empty;
  logic [JW-1:0] job_in, job_out;

  // The configuration port never stalls; the single register sits at word 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ttb_pkg::RegComputeEnable) ? 32'(enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == ttb_pkg::RegComputeEnable) begin
      enable_q <= pwdata[0];
    end
  end

  // Intake: holds vertices and raises one job request per enabled triangle.
  ttb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .tex_u_i    (tex_u_i),
    .tex_v_i    (tex_v_i),
    .enable_i   (enable_q),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Short queue so intake and sequencer stall independently.
  ttb_fifo #(
    .W(JW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Sequencer: products, normalization and the output register.
  ttb_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .job_i         (job_out),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .bitangent_x_o (bitangent_x_o),
    .bitangent_y_o (bitangent_y_o),
    .bitangent_z_o (bitangent_z_o),
    .degenerate_o  (degenerate_o)
  );

endmodule

[design/ttb_checker.sv]
// ----------------------------------------------------------------------------
// ttb_checker: port-level checks for the triangle tangent unit
// Watches the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
module ttb_checker #(
  parameter int COORD_WIDTH   = ttb_pkg::CoordWidthDef,
  parameter int OUT_FRAC_BITS = ttb_pkg::OutFracBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [COORD_WIDTH-1:0]       pos_x_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [OUT_FRAC_BITS+1:0]     tangent_x_o,
  input logic [OUT_FRAC_BITS+1:0]     tangent_y_o,
  input logic [OUT_FRAC_BITS+1:0]     tangent_z_o,
  input logic [OUT_FRAC_BITS+1:0]     bitangent_x_o,
  input logic [OUT_FRAC_BITS+1:0]     bitangent_y_o,
  input logic [OUT_FRAC_BITS+1:0]     bitangent_z_o,
  input logic                         degenerate_o,
  input logic                         pready
);

  localparam logic signed [OUT_FRAC_BITS+1:0] Lim = (OUT_FRAC_BITS+2)'(1) << OUT_FRAC_BITS;

  // A degenerate triangle carries all-zero vectors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0 &&
      bitangent_x_o == '0 && bitangent_y_o == '0 && bitangent_z_o == '0)
    else $error("degenerate result with non-zero vector");

  // Unit components never exceed one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(tangent_x_o) <= Lim && $signed(tangent_x_o) >= -Lim &&
      $signed(tangent_y_o) <= Lim && $signed(tangent_y_o) >= -Lim &&
      $signed(tangent_z_o) <= Lim && $signed(tangent_z_o) >= -Lim)
    else $error("tangent component out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(bitangent_x_o) <= Lim && $signed(bitangent_x_o) >= -Lim &&
      $signed(bitangent_y_o) <= Lim && $signed(bitangent_y_o) >= -Lim &&
      $signed(bitangent_z_o) <= Lim && $signed(bitangent_z_o) >= -Lim)
    else $error("bitangent component out of range");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(tangent_x_o) && $stable(bitangent_z_o) &&
      $stable(degenerate_o))
    else $error("stalled result changed");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ pos_x_i[0];

endmodule

bind triangle_tangent_bitangent_top ttb_checker #(
  .COORD_WIDTH  (COORD_WIDTH),
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_ttb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .pos_x_i       (pos_x_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .tangent_x_o   (tangent_x_o),
  .tangent_y_o   (tangent_y_o),
  .tangent_z_o   (tangent_z_o),
  .bitangent_x_o (bitangent_x_o),
  .bitangent_y_o (bitangent_y_o),
  .bitangent_z_o (bitangent_z_o),
  .degenerate_o  (degenerate_o),
  .pready        (pready)
);
